// ===== rtl/core/acasl_pkg.sv =====
// ----------------------------------------------------------------------------
// acasl_pkg
// Shared types and constants for the angle clamp, average and slew limiter.
// ----------------------------------------------------------------------------
package acasl_pkg;

	localparam int FRACTION_BITS = 8;
	localparam int SAMPLE_W      = 18;
	localparam int YAW_W         = 17;
	localparam int CFG_W         = 16;
	localparam int WIN_CFG_W     = 5;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ANGLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP      = 2'd3;

	localparam logic [CFG_W-1:0]     INITIAL_ANGLE_RST = CFG_W'(90 << FRACTION_BITS);
	localparam logic [CFG_W-1:0]     ANGLE_LIMIT_RST   = CFG_W'(45 << FRACTION_BITS);
	localparam logic [CFG_W-1:0]     MAX_STEP_RST      = CFG_W'(3 << FRACTION_BITS);
	localparam logic [WIN_CFG_W-1:0] WINDOW_SIZE_RST   = 5'd5;

	typedef struct packed {
		logic signed [YAW_W-1:0] yaw_angle;
		logic                    pose_valid;
		logic                    restart;
	} frame_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filt_angle;
		logic                       updated;
	} result_t;

endpackage

// ===== rtl/core/acasl_ram.sv =====
// ----------------------------------------------------------------------------
// acasl_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module acasl_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/acasl_div.sv =====
// ----------------------------------------------------------------------------
// acasl_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acasl_div #(
	parameter int DIVIDEND_W = 22,
	parameter int DIVISOR_W  = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  div_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  run_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    trial;
	logic                  ge;
	logic [DIVISOR_W-1:0]  rem_next;

	assign trial    = {rem_q, quo_q[DIVIDEND_W-1]};
	assign ge       = trial >= {1'b0, div_q};
	assign rem_next = ge ? DIVISOR_W'(trial - {1'b0, div_q}) : DIVISOR_W'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIVIDEND_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/angle_clamp_average_slew_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// angle_clamp_average_slew_limiter_unit
// Clamp a yaw-derived angle, average it over a sliding window, limit its slew.
// ----------------------------------------------------------------------------
// One frame transaction gives one result transaction. A frame with pose_valid
// set passes through the update, round, divide, slew and finish states before
// the next frame is accepted; the bit-serial divider that forms the window
// mean, one quotient bit per cycle, runs in the divide state. A frame without
// pose_valid goes straight to the finish state. The window samples live in a
// RAM of WINDOW_MAX entries, read for every accepted frame and rewritten once
// per valid frame. The result register lets the next frame be accepted while a
// result still waits. A new window_size takes effect at the next restart frame.
// ----------------------------------------------------------------------------
module angle_clamp_average_slew_limiter_unit #(
	parameter int WINDOW_MAX = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  frame_valid,
	output logic                                  frame_stall,
	input  acasl_pkg::frame_t                     frame,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output acasl_pkg::result_t                    result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [acasl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [acasl_pkg::CFG_W-1:0]           cfg_data
);

	localparam int SW      = acasl_pkg::SAMPLE_W;
	localparam int ACT_W   = $clog2(WINDOW_MAX + 1);
	localparam int SLOT_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int TOTAL_W = SW + $clog2(WINDOW_MAX);
	localparam int ACT_RST = (WINDOW_MAX < 5) ? WINDOW_MAX : 5;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_UPDATE = 3'd1;
	localparam logic [2:0] ST_ROUND  = 3'd2;
	localparam logic [2:0] ST_DIVIDE = 3'd3;
	localparam logic [2:0] ST_SLEW   = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [acasl_pkg::CFG_W-1:0]     initial_angle_q;
	logic [acasl_pkg::CFG_W-1:0]     angle_limit_q;
	logic [acasl_pkg::WIN_CFG_W-1:0] window_size_q;
	logic [acasl_pkg::CFG_W-1:0]     max_step_q;

	logic [2:0]                state_q;
	logic [ACT_W-1:0]          active_q;
	logic [ACT_W-1:0]          fill_q;
	logic [SLOT_W-1:0]         slot_q;
	logic [SLOT_W-1:0]         cur_slot_q;
	logic signed [TOTAL_W-1:0] total_q;
	logic signed [SW-1:0]      held_q;
	logic signed [SW-1:0]      sample_q;
	logic signed [SW-1:0]      mean_q;
	logic                      neg_q;
	logic                      upd_q;
	logic                      result_valid_q;
	acasl_pkg::result_t        result_q;

	logic                      accept;
	logic                      finish_fire;
	logic [ACT_W-1:0]          eff_window;
	logic [ACT_W-1:0]          act_sel;
	logic [SLOT_W-1:0]         slot_sel;
	logic signed [SW:0]        init_x;
	logic signed [SW:0]        limit_x;
	logic signed [SW:0]        diff;
	logic signed [SW:0]        lo;
	logic signed [SW:0]        hi;
	logic signed [SW-1:0]      clamped;
	logic [SW-1:0]             old_raw;
	logic signed [SW-1:0]      old_sample;
	logic                      full;
	logic signed [TOTAL_W-1:0] total_next;
	logic [ACT_W-1:0]          slot_inc;
	logic [TOTAL_W-1:0]        magnitude;
	logic [TOTAL_W-1:0]        dividend;
	logic                      div_start;
	logic                      div_done;
	logic [TOTAL_W-1:0]        quotient;
	logic signed [SW-1:0]      q_short;
	logic signed [SW:0]        delta;
	logic signed [SW:0]        step_x;
	logic signed [SW:0]        held_x;
	logic signed [SW-1:0]      held_slew;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_angle_q <= acasl_pkg::INITIAL_ANGLE_RST;
			angle_limit_q   <= acasl_pkg::ANGLE_LIMIT_RST;
			window_size_q   <= acasl_pkg::WINDOW_SIZE_RST;
			max_step_q      <= acasl_pkg::MAX_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				acasl_pkg::CFG_INITIAL_ANGLE: initial_angle_q <= cfg_data;
				acasl_pkg::CFG_ANGLE_LIMIT:   angle_limit_q   <= cfg_data;
				acasl_pkg::CFG_WINDOW_SIZE:
					window_size_q <= cfg_data[acasl_pkg::WIN_CFG_W-1:0];
				acasl_pkg::CFG_MAX_STEP:      max_step_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign frame_stall = (state_q != ST_IDLE);
	assign accept      = frame_valid && !frame_stall;
	assign finish_fire = (state_q == ST_FINISH) && (!result_valid_q || !result_stall);

	always_comb begin
		if (int'(window_size_q) > WINDOW_MAX) begin
			eff_window = ACT_W'(WINDOW_MAX);
		end else if (window_size_q == '0) begin
			eff_window = ACT_W'(1);
		end else begin
			eff_window = ACT_W'(window_size_q);
		end
	end

	assign act_sel  = frame.restart ? eff_window : active_q;
	assign slot_sel = (frame.restart || (ACT_W'(slot_q) >= act_sel)) ? '0 : slot_q;

	assign init_x  = signed'({{(SW + 1 - acasl_pkg::CFG_W){1'b0}}, initial_angle_q});
	assign limit_x = signed'({{(SW + 1 - acasl_pkg::CFG_W){1'b0}}, angle_limit_q});
	assign diff    = init_x - (SW + 1)'(frame.yaw_angle);
	assign lo      = init_x - limit_x;
	assign hi      = init_x + limit_x;

	always_comb begin
		priority if (diff < lo) begin
			clamped = SW'(lo);
		end else if (diff > hi) begin
			clamped = SW'(hi);
		end else begin
			clamped = SW'(diff);
		end
	end

	acasl_ram #(
		.WIDTH (SW),
		.DEPTH (WINDOW_MAX),
		.AW    (SLOT_W)
	) u_store (
		.clk     (clk),
		.wr_en   (state_q == ST_UPDATE),
		.wr_addr (cur_slot_q),
		.wr_data (sample_q),
		.rd_en   (accept),
		.rd_addr (slot_sel),
		.rd_data (old_raw)
	);

	assign old_sample = signed'(old_raw);
	assign full       = fill_q >= active_q;
	assign total_next = total_q + TOTAL_W'(sample_q)
		- (full ? TOTAL_W'(old_sample) : TOTAL_W'(0));
	assign slot_inc   = ACT_W'(cur_slot_q) + ACT_W'(1);

	assign magnitude = total_q[TOTAL_W-1] ? TOTAL_W'(-total_q) : TOTAL_W'(total_q);
	assign dividend  = magnitude + TOTAL_W'(fill_q >> 1);
	assign div_start = (state_q == ST_ROUND);

	acasl_div #(
		.DIVIDEND_W (TOTAL_W),
		.DIVISOR_W  (ACT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (fill_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign q_short = signed'(SW'(quotient));

	assign delta  = (SW + 1)'(mean_q) - (SW + 1)'(held_q);
	assign step_x = signed'({{(SW + 1 - acasl_pkg::CFG_W){1'b0}}, max_step_q});

	always_comb begin
		priority if (delta > step_x) begin
			held_x = (SW + 1)'(held_q) + step_x;
		end else if (delta < -step_x) begin
			held_x = (SW + 1)'(held_q) - step_x;
		end else begin
			held_x = (SW + 1)'(mean_q);
		end
	end

	assign held_slew = SW'(held_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			active_q       <= ACT_W'(ACT_RST);
			fill_q         <= '0;
			slot_q         <= '0;
			total_q        <= '0;
			held_q         <= SW'(acasl_pkg::INITIAL_ANGLE_RST);
			result_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (frame.restart) begin
							active_q <= eff_window;
							fill_q   <= '0;
							slot_q   <= '0;
							total_q  <= '0;
							held_q   <= SW'(initial_angle_q);
						end
						state_q <= frame.pose_valid ? ST_UPDATE : ST_FINISH;
					end
				end
				ST_UPDATE: begin
					if (!full) begin
						fill_q <= fill_q + 1'b1;
					end
					total_q <= total_next;
					slot_q  <= (slot_inc >= active_q) ? '0 : SLOT_W'(slot_inc);
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (div_done) begin
						state_q <= ST_SLEW;
					end
				end
				ST_SLEW: begin
					held_q  <= held_slew;
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (finish_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (finish_fire) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q   <= clamped;
			cur_slot_q <= slot_sel;
			upd_q      <= frame.pose_valid;
		end
		if (state_q == ST_ROUND) begin
			neg_q <= total_q[TOTAL_W-1];
		end
		if (div_done) begin
			mean_q <= neg_q ? -q_short : q_short;
		end
		if (finish_fire) begin
			result_q.filt_angle <= held_q;
			result_q.updated    <= upd_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= active_q)
		else $error("fill count exceeds active window");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ACT_W'(slot_q) < active_q)
		else $error("write slot outside active window");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_UPDATE || state_q == ST_FINISH))
		else $error("accepted frame did not start processing");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIVIDE)
		else $error("divider finished outside divide state");

endmodule
